[rtl/mwd_pkg.sv]
// ----------------------------------------------------------------------------
// mwd_pkg: shared definitions for the multiword divider
// Digit count, word widths and the control structs between the modules.
// ----------------------------------------------------------------------------
package mwd_pkg;

    // Number of 16-bit digits in each operand.
    localparam int DIGITS = 16;
    localparam int DW     = 16;
    localparam int WW     = DIGITS * DW;
    localparam int PW     = $clog2(DIGITS + 1);
    localparam int IW     = $clog2(DIGITS);
    localparam int BW     = $clog2(WW);

    // Status codes.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DIV_ZERO = 1'b1;

    // Control from the sequencer to the divider core.
    typedef struct packed {
        logic start;
    } core_ctrl_t;

    // Status from the divider core back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
        logic div_zero;
    } core_stat_t;

    // Top-level sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_EMIT  = 4'b1000
    } seq_state_t;

endpackage

[rtl/multiword_divider_top.sv]
// ----------------------------------------------------------------------------
// multiword_divider_top: unsigned multiword divider, 16-bit digits
// Digit pairs load one per cycle while idle, least significant first; the
// pair with final_pair set starts the division; DIGITS result items follow.
// ----------------------------------------------------------------------------
// The division is done by the restoring divider core, which yields one
// quotient bit per cycle; results then leave at up to one per cycle, as
// result_stall allows. A zero divisor gives zero digits with status 1.
// Inputs are stalled from the final pair until the last result item has
// been taken.
module multiword_divider_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [mwd_pkg::DW-1:0] dividend_digit,
    input  logic [mwd_pkg::DW-1:0] divisor_digit,
    input  logic                   final_pair,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [mwd_pkg::DW-1:0] quotient_digit,
    output logic [mwd_pkg::DW-1:0] remainder_digit,
    output logic                   status,
    output logic                   last_digit
);
    import mwd_pkg::*;

    seq_state_t    state_reg;
    seq_state_t    state_next;
    logic [IW-1:0] idx_reg;
    logic          valid_reg;
    logic [DW-1:0] quot_digit_reg;
    logic [DW-1:0] rem_digit_reg;
    logic          status_reg;
    logic          last_reg;

    logic          in_fire;
    logic          out_fire;
    logic          load_out;
    logic [IW-1:0] sel_idx;
    logic [WW-1:0] dividend;
    logic [WW-1:0] divisor;
    logic [WW-1:0] quotient;
    logic [WW-1:0] remainder;
    core_ctrl_t    ctrl;
    core_stat_t    stat;

    assign in_fire  = item_valid && !item_stall;
    assign out_fire = result_valid && !result_stall;
    assign ctrl.start = (state_reg == ST_START);

    mwd_operands u_operands (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (in_fire),
        .clear          (ctrl.start),
        .dividend_digit (dividend_digit),
        .divisor_digit  (divisor_digit),
        .dividend       (dividend),
        .divisor        (divisor)
    );

    mwd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .dividend  (dividend),
        .divisor   (divisor),
        .stat      (stat),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire && final_pair) state_next = ST_START;
            ST_START: state_next = ST_RUN;
            ST_RUN:   if (stat.done) state_next = ST_EMIT;
            ST_EMIT:  if (out_fire && last_reg) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // The output register loads at the end of the division and after each take but the last.
    assign load_out = (state_reg == ST_RUN && stat.done) || (out_fire && !last_reg);
    assign sel_idx  = (state_reg == ST_RUN) ? '0 : idx_reg + IW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= sel_idx;
                last_reg  <= (sel_idx == IW'(DIGITS - 1));
            end
            else if (out_fire)
            begin
                valid_reg <= 1'b0;
                last_reg  <= 1'b0;
            end
        end
    end

    // Result payload; a zero divisor forces zero digits.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            quot_digit_reg <= stat.div_zero ? '0 : quotient[sel_idx*DW +: DW];
            rem_digit_reg  <= stat.div_zero ? '0 : remainder[sel_idx*DW +: DW];
            status_reg     <= stat.div_zero ? STATUS_DIV_ZERO : STATUS_OK;
        end
    end

    assign item_stall      = (state_reg != ST_IDLE);
    assign result_valid    = valid_reg;
    assign quotient_digit  = quot_digit_reg;
    assign remainder_digit = rem_digit_reg;
    assign status          = status_reg;
    assign last_digit      = last_reg;

endmodule

[rtl/mwd_operands.sv]
// ----------------------------------------------------------------------------
// mwd_operands: operand digit store
// Collects dividend and divisor digits least significant first and clears
// both operands once a division has taken them.
// ----------------------------------------------------------------------------
module mwd_operands (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 clear,
    input  logic [mwd_pkg::DW-1:0] dividend_digit,
    input  logic [mwd_pkg::DW-1:0] divisor_digit,
    output logic [mwd_pkg::WW-1:0] dividend,
    output logic [mwd_pkg::WW-1:0] divisor
);
    import mwd_pkg::*;

    logic [WW-1:0] dividend_reg;
    logic [WW-1:0] divisor_reg;
    logic [PW-1:0] pos_reg;

    // Store each digit at the load position; extra digits are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dividend_reg <= '0;
            divisor_reg  <= '0;
            pos_reg      <= '0;
        end
        else if (clear)
        begin
            dividend_reg <= '0;
            divisor_reg  <= '0;
            pos_reg      <= '0;
        end
        else if (load && (pos_reg < PW'(DIGITS)))
        begin
            dividend_reg[pos_reg[IW-1:0]*DW +: DW] <= dividend_digit;
            divisor_reg[pos_reg[IW-1:0]*DW +: DW]  <= divisor_digit;
            pos_reg <= pos_reg + PW'(1);
        end
    end

    assign dividend = dividend_reg;
    assign divisor  = divisor_reg;

endmodule

[rtl/mwd_core.sv]
// ----------------------------------------------------------------------------
// mwd_core: iterative restoring divider
// One shared compare-and-subtract unit produces one quotient bit per cycle,
// most significant bit first, over the whole operand width.
// ----------------------------------------------------------------------------
module mwd_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mwd_pkg::core_ctrl_t    ctrl,
    input  logic [mwd_pkg::WW-1:0] dividend,
    input  logic [mwd_pkg::WW-1:0] divisor,
    output mwd_pkg::core_stat_t    stat,
    output logic [mwd_pkg::WW-1:0] quotient,
    output logic [mwd_pkg::WW-1:0] remainder
);
    import mwd_pkg::*;

    logic [WW-1:0] quot_reg;
    logic [WW-1:0] rem_reg;
    logic [WW-1:0] div_reg;
    logic [BW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          zero_reg;

    logic [WW:0]   trial;
    logic [WW:0]   diff;
    logic          fits;

    // Shared unit: shift in the next dividend bit and try the subtraction.
    assign trial = {rem_reg, quot_reg[WW-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    // Sequencing of the bit iterations.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= BW'(WW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - BW'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient bits replace the dividend bits as they shift out.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[WW-2:0], fits};
            rem_reg  <= fits ? diff[WW-1:0] : trial[WW-1:0];
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.div_zero = zero_reg;
    assign quotient      = quot_reg;
    assign remainder     = rem_reg;

endmodule

[rtl/mwd_checker.sv]
// ----------------------------------------------------------------------------
// mwd_checker: port-level checks for the multiword divider
// Watches the top-level handshakes and result fields over time.
// ----------------------------------------------------------------------------
module mwd_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_stall,
    input logic                   final_pair,
    input logic                   result_valid,
    input logic                   result_stall,
    input logic [mwd_pkg::DW-1:0] quotient_digit,
    input logic [mwd_pkg::DW-1:0] remainder_digit,
    input logic                   status,
    input logic                   last_digit
);
    import mwd_pkg::*;

    // Inputs stay stalled while results are being delivered.
    a_stall_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("item taken while results pending");

    // A final pair starts a division, so the next cycle stalls inputs.
    a_final_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && final_pair) |=> item_stall)
        else $error("no stall after final pair");

    // A zero divisor reports zero digits.
    a_zero_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == STATUS_DIV_ZERO) |->
            (quotient_digit == '0 && remainder_digit == '0))
        else $error("nonzero digit with zero divisor");

    // Taking the most significant digit ends the result sequence.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && last_digit) |=> !result_valid)
        else $error("result after last digit");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(quotient_digit) && $stable(remainder_digit)
             && $stable(status) && $stable(last_digit)))
        else $error("stalled result changed");

endmodule

bind multiword_divider_top mwd_checker u_mwd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .final_pair      (final_pair),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .quotient_digit  (quotient_digit),
    .remainder_digit (remainder_digit),
    .status          (status),
    .last_digit      (last_digit)
);

[tb/tb_multiword_divider_top.sv]
// ----------------------------------------------------------------------------
// tb_multiword_divider_top: self-checking bench for the multiword divider
// Loads digit pairs, takes the sixteen result items of each division from the
// table or predicts them with wide unsigned arithmetic, and checks every
// result item in order under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_multiword_divider_top;
    import mwd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;

    typedef struct {
        logic [WW-1:0] dividend;
        logic [WW-1:0] divisor;
        int            pairs;
        bit            typed;
        logic [WW-1:0] quo;
        logic [WW-1:0] rem;
        logic          st;
    } division_row_t;

    typedef struct {
        logic [DW-1:0] quo;
        logic [DW-1:0] rem;
        logic          st;
        logic          last;
    } digit_result_t;

    logic          clk;
    logic          rst_n;
    logic          item_valid;
    logic          item_stall;
    logic [DW-1:0] dividend_digit;
    logic [DW-1:0] divisor_digit;
    logic          final_pair;
    logic          result_valid;
    logic          result_stall;
    logic [DW-1:0] quotient_digit;
    logic [DW-1:0] remainder_digit;
    logic          status;
    logic          last_digit;

    digit_result_t pending_digits[$];
    logic [DW-1:0] shadow_dividend[DIGITS];
    logic [DW-1:0] shadow_divisor[DIGITS];
    int            shadow_fill;
    int            errors;
    int            idle_cycles;
    int            divisions_sent;
    int            results_seen;
    int            hold_left;
    bit            hold_done;
    bit            sender_quiet;
    division_row_t directed[11];

    multiword_divider_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .dividend_digit  (dividend_digit),
        .divisor_digit   (divisor_digit),
        .final_pair      (final_pair),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .quotient_digit  (quotient_digit),
        .remainder_digit (remainder_digit),
        .status          (status),
        .last_digit      (last_digit)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Queue the sixteen digit results of one division.
    task automatic queue_quotient(input logic [WW-1:0] quo, input logic [WW-1:0] rem,
                                  input logic st);
        digit_result_t d;
        for (int i = 0; i < DIGITS; i++)
        begin
            d.quo  = quo[i*DW +: DW];
            d.rem  = rem[i*DW +: DW];
            d.st   = st;
            d.last = (i == DIGITS - 1);
            pending_digits.push_back(d);
        end
    endtask

    // Track one accepted pair; on the final pair, divide the stored operands.
    task automatic absorb_pair(input logic [DW-1:0] a, input logic [DW-1:0] b,
                               input logic fin, input bit typed,
                               input logic [WW-1:0] tq, input logic [WW-1:0] tr,
                               input logic tst);
        logic [WW-1:0] num;
        logic [WW-1:0] den;
        if (shadow_fill < DIGITS)
        begin
            shadow_dividend[shadow_fill] = a;
            shadow_divisor[shadow_fill]  = b;
            shadow_fill++;
        end
        if (fin)
        begin
            num = '0;
            den = '0;
            for (int i = 0; i < DIGITS; i++)
            begin
                num[i*DW +: DW] = shadow_dividend[i];
                den[i*DW +: DW] = shadow_divisor[i];
            end
            if (typed)
                queue_quotient(tq, tr, tst);
            else if (den == '0)
                queue_quotient('0, '0, STATUS_DIV_ZERO);
            else
                queue_quotient(num / den, num % den, STATUS_OK);
            for (int i = 0; i < DIGITS; i++)
            begin
                shadow_dividend[i] = '0;
                shadow_divisor[i]  = '0;
            end
            shadow_fill = 0;
        end
    endtask

    // Offer one pair until it is accepted, idling at random beforehand.
    task automatic offer_pair(input logic [DW-1:0] a, input logic [DW-1:0] b,
                              input logic fin);
        while (!sender_quiet && $urandom_range(0, 99) < 23)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid     <= 1'b1;
        dividend_digit <= a;
        divisor_digit  <= b;
        final_pair     <= fin;
        do @(posedge clk); while (item_stall);
    endtask

    // Send one division as a run of pairs, then drop valid.
    task automatic send_division(input division_row_t row);
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        for (int p = 0; p < row.pairs; p++)
        begin
            a = (p < DIGITS) ? row.dividend[p*DW +: DW] : DW'($urandom);
            b = (p < DIGITS) ? row.divisor[p*DW +: DW] : DW'($urandom);
            offer_pair(a, b, p == row.pairs - 1);
            absorb_pair(a, b, p == row.pairs - 1, row.typed, row.quo, row.rem, row.st);
        end
        item_valid <= 1'b0;
        divisions_sent++;
        @(posedge clk);
    endtask

    function automatic logic [DW-1:0] pick_digit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 16'h8000;
            default: return DW'($urandom);
        endcase
    endfunction

    function automatic division_row_t random_row();
        division_row_t r;
        int la;
        int lb;
        la = $urandom_range(1, DIGITS);
        lb = ($urandom_range(0, 9) < 7) ? $urandom_range(1, la) : $urandom_range(1, DIGITS);
        r = '{default: '0};
        for (int i = 0; i < DIGITS; i++)
        begin
            if (i < la) r.dividend[i*DW +: DW] = pick_digit();
            if (i < lb) r.divisor[i*DW +: DW]  = pick_digit();
        end
        // Force the top divisor digit near the dividend's top digit.
        if ($urandom_range(0, 3) == 0)
            r.divisor[(lb-1)*DW +: DW] = r.dividend[(la-1)*DW +: DW] | 16'h0001;
        if ($urandom_range(0, 9) == 0)
            r.divisor = '0;
        r.pairs = (la > lb) ? la : lb;
        if ($urandom_range(0, 9) == 0)
            r.pairs = $urandom_range(DIGITS + 1, DIGITS + 3);
        else if ($urandom_range(0, 4) == 0)
            r.pairs = $urandom_range(r.pairs, DIGITS);
        return r;
    endfunction

    // Result checking, receiver stall and the long hold-off.
    always @(posedge clk)
    begin
        digit_result_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_digits.size() == 0)
            begin
                $display("%0t: unexpected result item q=%h r=%h", $time,
                         quotient_digit, remainder_digit);
                errors++;
            end
            else
            begin
                e = pending_digits.pop_front();
                if (quotient_digit !== e.quo)
                begin
                    $display("%0t: quotient_digit expected %h actual %h", $time, e.quo,
                             quotient_digit);
                    errors++;
                end
                if (remainder_digit !== e.rem)
                begin
                    $display("%0t: remainder_digit expected %h actual %h", $time, e.rem,
                             remainder_digit);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %b actual %b", $time, e.st, status);
                    errors++;
                end
                if (last_digit !== e.last)
                begin
                    $display("%0t: last_digit expected %b actual %b", $time, e.last,
                             last_digit);
                    errors++;
                end
            end
            results_seen++;
        end
        if (!hold_done && divisions_sent == 6)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (results_seen >= 400 && results_seen < 640)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 99) < 23);
    end

    // Watchdog on cycles with no accepted item on either channel.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus: directed table, then random divisions.
    initial
    begin
        int items;
        division_row_t row;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        dividend_digit = '0;
        divisor_digit  = '0;
        final_pair     = 1'b0;
        result_stall   = 1'b0;
        errors         = 0;
        idle_cycles    = 0;
        divisions_sent = 0;
        results_seen   = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        sender_quiet   = 1'b0;
        shadow_fill    = 0;
        for (int i = 0; i < DIGITS; i++)
        begin
            shadow_dividend[i] = '0;
            shadow_divisor[i]  = '0;
        end

        // Zero over zero, right after reset.
        directed[0]  = '{'0, '0, 1, 1'b1, '0, '0, STATUS_DIV_ZERO};
        // Full dividend over one.
        directed[1]  = '{'1, WW'(1), 16, 1'b1, '1, '0, STATUS_OK};
        // Small dividend below a one-digit divisor.
        directed[2]  = '{WW'(5), WW'(7), 1, 1'b1, '0, WW'(5), STATUS_OK};
        directed[3]  = '{WW'(16'hffff), WW'(7), 1, 1'b0, '0, '0, STATUS_OK};
        // Full over full.
        directed[4]  = '{'1, '1, 16, 1'b1, WW'(1), '0, STATUS_OK};
        directed[5]  = '{'1, {16'h8000, 240'h0}, 16, 1'b0, '0, '0, STATUS_OK};
        // Dividend shorter than divisor.
        directed[6]  = '{WW'(16'h1234), WW'(1) << 64, 5, 1'b1, '0, WW'(16'h1234), STATUS_OK};
        // Pairs past the last position are ignored.
        directed[7]  = '{'1, WW'(48'h0001_ffff_0003), 19, 1'b0, '0, '0, STATUS_OK};
        // Zero divisor with a full dividend.
        directed[8]  = '{'1, '0, 16, 1'b1, '0, '0, STATUS_DIV_ZERO};
        // Top digits equal.
        directed[9]  = '{{16'h8000, 16'h0000, 16'h0000, 208'h0},
                         {64'h0, 16'h8000, 16'h0000, 16'h0001, 144'h0}, 16, 1'b0,
                         '0, '0, STATUS_OK};
        directed[10] = '{{16'h7fff, 16'h8000, 16'h0000, 208'h0},
                         {48'h0, 16'h8000, 16'h0000, 16'h0001, 160'h0}, 16, 1'b0,
                         '0, '0, STATUS_OK};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        items = 0;
        foreach (directed[i])
        begin
            send_division(directed[i]);
            items += directed[i].pairs;
        end

        while (items < 500)
        begin
            row = random_row();
            sender_quiet = (divisions_sent >= 24 && divisions_sent < 34);
            // Let the block drain completely once before going on.
            if (divisions_sent == 18)
                while (pending_digits.size() != 0) @(posedge clk);
            send_division(row);
            items += row.pairs;
        end

        while (pending_digits.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
